/* rtl/lagrange_resampler_core_macros.svh */
// assertion macros for the lagrange resampler core
// expects signals named clk and rst in the module that uses them
`ifndef LAGRANGE_RESAMPLER_CORE_MACROS_SVH
`define LAGRANGE_RESAMPLER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define LRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle
`define LRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the next cycle
`define LRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lrs_pkg.sv */
// shared constants, types and small constant tables of the lagrange resampler
// no dependencies
package lrs_pkg;

  localparam int HALF_WINDOW     = 3;
  localparam int WIN_LEN         = 2 * HALF_WINDOW + 1;
  localparam int PTS_W           = 3;
  localparam int FRAC_W          = 16;

  localparam int RATIO_W         = 19;
  localparam logic [RATIO_W-1:0] RATIO_MIN   = 19'd13107;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 19'd262144;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 19'd65536;
  localparam int QUO_W           = 33;
  localparam int QCNT_W          = 6;

  localparam int MAX_RESULTS     = 20;
  localparam int CNT_W           = 5;
  localparam int MAX_SEGMENT_DEF = 1048576;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int NUM_W   = 34;
  localparam int U_W     = 18;
  localparam int FAC_W   = 20;
  localparam int Y_W     = 36;
  localparam int DIG_W   = 12;
  localparam int NDIG    = 3;
  localparam int DEN_W   = 10;
  localparam int RCP_W   = 33;
  localparam int Z_W     = DEN_W + DIG_W;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 34;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic               busy;
    logic [RATIO_W-1:0] quo;
    logic [RATIO_W-1:0] rem;
  } rdiv_res_t;

  function automatic logic [DEN_W-1:0] fact(input logic [PTS_W-1:0] n);
    logic [DEN_W-1:0] f;
    unique case (n)
      3'd0, 3'd1: f = 10'd1;
      3'd2:       f = 10'd2;
      3'd3:       f = 10'd6;
      3'd4:       f = 10'd24;
      3'd5:       f = 10'd120;
      3'd6:       f = 10'd720;
      default:    f = 10'd1;
    endcase
    return f;
  endfunction

  // magnitude of the node product over k != j of (j - k)
  function automatic logic [DEN_W-1:0] den_mag(input logic [PTS_W-1:0] npts,
                                               input logic [PTS_W-1:0] j);
    logic [PTS_W-1:0]   rest;
    logic [2*DEN_W-1:0] p;
    rest = npts - j - 3'd1;
    p    = fact(j) * fact(rest);
    return p[DEN_W-1:0];
  endfunction

  // ceil(2^32 / d), exact floor for dividends below 2^22
  function automatic logic [RCP_W-1:0] recip(input logic [DEN_W-1:0] d);
    logic [RCP_W-1:0] r;
    unique case (d)
      10'd1:   r = 33'd4294967296;
      10'd2:   r = 33'd2147483648;
      10'd4:   r = 33'd1073741824;
      10'd6:   r = 33'd715827883;
      10'd12:  r = 33'd357913942;
      10'd24:  r = 33'd178956971;
      10'd36:  r = 33'd119304648;
      10'd48:  r = 33'd89478486;
      10'd120: r = 33'd35791395;
      10'd720: r = 33'd5965233;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/lrs_mul.sv */
// shared signed multiplier with registered product
// depends on lrs_pkg
module lrs_mul
  import lrs_pkg::*;
(
  input  logic                     clk,
  input  mul_op_t                  op,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

/* rtl/lrs_rdiv.sv */
// bit-serial restoring divider giving floor(2^32 / ratio) and its remainder
// depends on lrs_pkg
module lrs_rdiv
  import lrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RATIO_W-1:0] divisor,
  output rdiv_res_t          res
);

  logic               busy;
  logic [QCNT_W-1:0]  cnt;
  logic [RATIO_W-1:0] rem;
  logic [RATIO_W-1:0] dvs;
  logic [QUO_W-1:0]   quo;
  logic [RATIO_W:0]   trial;
  logic [RATIO_W:0]   diff;
  logic               ge;

  // dividend is a single one in its top bit
  assign trial = {rem, (cnt == QCNT_W'(QUO_W - 1))};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= QCNT_W'(QUO_W - 1);
      rem  <= '0;
      quo  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  assign res.busy = busy;
  assign res.quo  = quo[RATIO_W-1:0];
  assign res.rem  = rem;

endmodule

/* rtl/lagrange_resampler_core.sv */
// an input item that releases no output word passes through the check and finish states;
// each output word runs the node products, weight divisions and sums of its window on the
// shared multiplier and waits in the emit state while the output is stalled
// the first sample of a segment also waits for the ratio reciprocal divider
// a new input item is taken only in the idle state, once the last one is finished
// reset: synchronous, clears window, counters, handshake state; ratio register to 1.0
`include "lagrange_resampler_core_macros.svh"
module lagrange_resampler_core
  import lrs_pkg::*;
#(
  parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [RATIO_W-1:0]     ratio_q16,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last_out
);

  localparam int MW    = $clog2(MAX_SEGMENT);
  localparam int IW    = MW + 4;
  localparam int PW    = IW + FRAC_W;
  localparam int ACC_W = MUL_A_W + SAMPLE_BITS + 3;
  localparam logic [MW-1:0] M_LAST = MW'(MAX_SEGMENT - 1);
  localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0]  A_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDIV, S_CHECK, S_SETUP, S_PT_INIT, S_NUM_SEL, S_NUM_ACC, S_DIV_INIT,
    S_DIG_MUL, S_DIG_REM, S_DIG_UPD, S_ACC_MUL, S_ACC_ADD, S_ROUND, S_EMIT, S_FINISH
  } state_t;

  state_t                         state;
  logic        [RATIO_W-1:0]      ratio_cfg;
  logic        [RATIO_W-1:0]      ratio_live;
  logic        [MW-1:0]           m;
  logic                           last_seg;
  logic        [PW-1:0]           pos;
  logic        [RATIO_W-1:0]      pos_rem;
  logic        [CNT_W-1:0]        cnt_out;
  logic signed [SAMPLE_BITS-1:0]  win [WIN_LEN];
  logic        [IW-1:0]           beg;
  logic        [U_W-1:0]          u;
  logic        [PTS_W-1:0]        npts;
  logic        [PTS_W-1:0]        j;
  logic        [PTS_W-1:0]        k;
  logic signed [NUM_W-1:0]        num;
  logic                           neg;
  logic        [DEN_W-1:0]        dmag;
  logic        [RCP_W-1:0]        rcp;
  logic        [Y_W-1:0]          y;
  logic        [Y_W-1:0]          qacc;
  logic        [DEN_W-1:0]        rem_d;
  logic        [Z_W-1:0]          z;
  logic        [1:0]              dig;
  logic signed [ACC_W-1:0]        acc;
  logic signed [SAMPLE_BITS-1:0]  res;
  logic                           out_valid_r;
  logic                           out_last_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;

  mul_op_t                        mop;
  logic signed [PROD_W-1:0]       prod;
  rdiv_res_t                      rdiv;
  logic                           rdiv_start;
  logic        [RATIO_W-1:0]      ratio_clamp;
  logic                           take;

  logic        [IW-1:0]           integ;
  logic        [IW-1:0]           m_ext;
  logic                           emit_ok;
  logic        [IW-1:0]           beg_c;
  logic        [IW-1:0]           end_c;
  logic        [IW-1:0]           span;
  logic        [IW-1:0]           diff_c;
  logic signed [FAC_W-1:0]        factor;
  logic        [IW-1:0]           age;
  logic        [PTS_W-1:0]        widx;
  logic signed [SAMPLE_BITS-1:0]  s_sel;
  logic        [DIG_W-1:0]        digit;
  logic        [Z_W-1:0]          z_c;
  logic        [DIG_W-1:0]        qd;
  logic        [Z_W-1:0]          rem_full;
  logic        [NUM_W-1:0]        num_abs;
  logic        [DEN_W-1:0]        dm_c;
  logic        [PTS_W-1:0]        rest_c;
  logic signed [MUL_A_W-1:0]      w;
  logic signed [PROD_W-1:0]       prod_rnd;
  logic signed [ACC_W-1:0]        acc_rnd;
  logic        [RATIO_W:0]        rsum;
  logic                           wrap;
  logic        [RATIO_W:0]        rsum_red;

  lrs_mul u_mul (
    .clk  (clk),
    .op   (mop),
    .prod (prod)
  );

  lrs_rdiv u_rdiv (
    .clk     (clk),
    .rst     (rst),
    .start   (rdiv_start),
    .divisor (ratio_clamp),
    .res     (rdiv)
  );

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == S_IDLE);
  assign take       = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign sample_out = out_sample_r;
  assign last_out   = out_last_r;

  assign ratio_clamp = (ratio_cfg < RATIO_MIN) ? RATIO_MIN :
                       (ratio_cfg > RATIO_MAX) ? RATIO_MAX : ratio_cfg;
  assign rdiv_start  = take && (m == '0);

  assign integ   = pos[PW-1:FRAC_W];
  assign m_ext   = {{(IW-MW){1'b0}}, m};
  // capped at MAX_RESULTS; flush releases up to segment end, else waits for full window
  assign emit_ok = (cnt_out < CNT_W'(MAX_RESULTS)) &&
                   (last_seg ? (integ <= m_ext) :
                    ({1'b0, integ} + (IW+1)'(HALF_WINDOW) <= {1'b0, m_ext}));

  assign beg_c  = (integ >= IW'(HALF_WINDOW)) ? integ - IW'(HALF_WINDOW) : '0;
  assign end_c  = (integ + IW'(HALF_WINDOW) < m_ext) ? integ + IW'(HALF_WINDOW) : m_ext;
  assign span   = end_c - beg_c + IW'(1);
  assign diff_c = integ - beg_c;
  assign factor = $signed({2'b00, u}) - $signed({1'b0, k, {FRAC_W{1'b0}}});

  assign age   = m_ext - (beg + IW'(j));
  assign widx  = PTS_W'(WIN_LEN - 1) - age[PTS_W-1:0];
  assign s_sel = (age < IW'(WIN_LEN)) ? win[widx] : '0;

  always_comb begin
    case (dig)
      2'd0:    digit = y[Y_W-1 -: DIG_W];
      2'd1:    digit = y[Y_W-DIG_W-1 -: DIG_W];
      default: digit = y[DIG_W-1:0];
    endcase
  end

  assign z_c      = {rem_d, digit};
  assign qd       = prod[RCP_W-1 +: DIG_W];
  assign rem_full = z - prod[Z_W-1:0];
  assign num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dm_c     = den_mag(npts, j);
  assign rest_c   = npts - j - PTS_W'(1);
  assign w        = neg ? -$signed(qacc) : $signed(qacc);
  assign prod_rnd = (prod + P_HALF) >>> FRAC_W;
  assign acc_rnd  = (acc + A_HALF) >>> FRAC_W;
  assign rsum     = {1'b0, pos_rem} + {1'b0, rdiv.rem};
  assign wrap     = rsum >= {1'b0, ratio_live};
  assign rsum_red = rsum - {1'b0, ratio_live};

  always_comb begin
    mop = '0;
    unique case (state)
      S_NUM_SEL: begin
        mop.a = {{(MUL_A_W-NUM_W){num[NUM_W-1]}}, num};
        mop.b = {{(MUL_B_W-FAC_W){factor[FAC_W-1]}}, factor};
      end
      S_DIG_MUL: begin
        mop.a = {{(MUL_A_W-Z_W){1'b0}}, z_c};
        mop.b = {{(MUL_B_W-RCP_W){1'b0}}, rcp};
      end
      S_DIG_REM: begin
        mop.a = {{(MUL_A_W-DIG_W){1'b0}}, qd};
        mop.b = {{(MUL_B_W-DEN_W){1'b0}}, dmag};
      end
      S_ACC_MUL: begin
        mop.a = w;
        mop.b = {{(MUL_B_W-SAMPLE_BITS){s_sel[SAMPLE_BITS-1]}}, s_sel};
      end
      default: mop = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ratio_cfg   <= RATIO_RESET;
      ratio_live  <= RATIO_RESET;
      m           <= '0;
      last_seg    <= 1'b0;
      cnt_out     <= '0;
      pos         <= '0;
      pos_rem     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        ratio_cfg <= ratio_q16;
      end
      // the emit state drives the output register itself
      if (out_valid_r && out_ready && state != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
              win[i] <= win[i+1];
            end
            win[WIN_LEN-1] <= sample_in;
            last_seg <= last_in || (m == M_LAST);
            cnt_out  <= '0;
            if (m == '0) begin
              ratio_live <= ratio_clamp;
              pos        <= '0;
              pos_rem    <= '0;
              state      <= S_RDIV;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_RDIV: begin
          if (!rdiv.busy) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= emit_ok ? S_SETUP : S_FINISH;
        end
        S_SETUP: begin
          beg   <= beg_c;
          u     <= {diff_c[U_W-FRAC_W-1:0], pos[FRAC_W-1:0]};
          npts  <= span[PTS_W-1:0];
          j     <= '0;
          acc   <= '0;
          state <= S_PT_INIT;
        end
        S_PT_INIT: begin
          num   <= NUM_W'(1 << FRAC_W);
          k     <= '0;
          state <= S_NUM_SEL;
        end
        S_NUM_SEL: begin
          if (k == npts) begin
            state <= S_DIV_INIT;
          end else if (k == j) begin
            k <= k + PTS_W'(1);
          end else begin
            state <= S_NUM_ACC;
          end
        end
        S_NUM_ACC: begin
          num   <= prod_rnd[NUM_W-1:0];
          k     <= k + PTS_W'(1);
          state <= S_NUM_SEL;
        end
        S_DIV_INIT: begin
          // round to nearest by dividing |num| + d/2, sign restored afterwards
          dmag  <= dm_c;
          rcp   <= recip(dm_c);
          neg   <= num[NUM_W-1] ^ rest_c[0];
          y     <= Y_W'(num_abs) + Y_W'(dm_c >> 1);
          rem_d <= '0;
          dig   <= '0;
          qacc  <= '0;
          state <= S_DIG_MUL;
        end
        S_DIG_MUL: begin
          z     <= z_c;
          state <= S_DIG_REM;
        end
        S_DIG_REM: begin
          qacc  <= {qacc[Y_W-DIG_W-1:0], qd};
          state <= S_DIG_UPD;
        end
        S_DIG_UPD: begin
          rem_d <= rem_full[DEN_W-1:0];
          if (dig == 2'(NDIG - 1)) begin
            state <= S_ACC_MUL;
          end else begin
            dig   <= dig + 2'd1;
            state <= S_DIG_MUL;
          end
        end
        S_ACC_MUL: begin
          state <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          acc <= acc + prod[ACC_W-1:0];
          if (j == npts - PTS_W'(1)) begin
            state <= S_ROUND;
          end else begin
            j     <= j + PTS_W'(1);
            state <= S_PT_INIT;
          end
        end
        S_ROUND: begin
          if (acc_rnd > SAT_HI) begin
            res <= SAT_HI[SAMPLE_BITS-1:0];
          end else if (acc_rnd < SAT_LO) begin
            res <= SAT_LO[SAMPLE_BITS-1:0];
          end else begin
            res <= acc_rnd[SAMPLE_BITS-1:0];
          end
          // step to the next output position
          pos_rem <= wrap ? rsum_red[RATIO_W-1:0] : rsum[RATIO_W-1:0];
          pos     <= pos + PW'(rdiv.quo) + PW'(wrap);
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res;
            out_last_r   <= last_seg && (integ > m_ext);
            cnt_out      <= cnt_out + CNT_W'(1);
            state        <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (last_seg) begin
            m <= '0;
            for (int i = 0; i < WIN_LEN; i++) begin
              win[i] <= '0;
            end
          end else begin
            m <= m + MW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LRS_ASSERT_ALWAYS(a_cnt_cap, cnt_out <= CNT_W'(MAX_RESULTS), "output count over limit")
  `LRS_ASSERT_IMP(a_rem_range, state == S_CHECK, pos_rem < ratio_live, "position remainder out of range")
  `LRS_ASSERT_IMP(a_pt_range, state == S_ACC_ADD, j < npts, "node index beyond window")
  `LRS_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "took a second word at once")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for lagrange_resampler_core: random segments, ratio writes and
// handshake idling, checked word by word against an in-bench interpolation model; uses lrs_pkg
module tb;
  import lrs_pkg::*;

  typedef enum logic [1:0] {K_SAMPLE, K_RATIO, K_DRAIN} job_kind_t;
  typedef struct {
    job_kind_t          kind;
    logic signed [15:0] smp;
    logic               lst;
    logic [RATIO_W-1:0] ratio;
  } job_t;
  typedef struct {
    logic signed [15:0] smp;
    logic               lst;
  } out_word_t;

  localparam int QUIET     = 400;
  localparam int MAX_CYCLE = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0, in_valid = 1'b0, out_ready = 1'b0, last_in = 1'b0;
  logic [RATIO_W-1:0] ratio_q16 = '0;
  logic signed [15:0] sample_in = '0;
  logic cfg_ready, in_ready, out_valid, last_out;
  logic signed [15:0] sample_out;

  lagrange_resampler_core u_top (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .ratio_q16(ratio_q16), .in_valid(in_valid), .in_ready(in_ready),
    .sample_in(sample_in), .last_in(last_in), .out_valid(out_valid),
    .out_ready(out_ready), .sample_out(sample_out), .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_t      jobs[$];
  out_word_t expected_words[$];
  longint    window[WIN_LEN];
  longint    seg_inputs, seg_outputs, ratio_reg, ratio_seg;
  int        fails = 0, quiet = 0, cycles = 0, gap = 0, ostall = 0, nogap_left = 0;
  bit        in_took = 0, cfg_took = 0, stim_done = 0;

  function automatic longint rnd16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint div_nearest(input longint num, input longint den);
    longint un, ud, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q  = (un + ud / 2) / ud;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [15:0] interp_at(input longint pos, input longint m);
    longint integ, beg, fin, u, cnt, acc, num, den, age, s;
    integ = pos >>> 16;
    beg = integ >= HALF_WINDOW ? integ - HALF_WINDOW : 0;
    fin = integ + HALF_WINDOW < m ? integ + HALF_WINDOW : m;
    u   = ((integ - beg) << 16) + (pos & 64'hFFFF);
    cnt = fin - beg + 1;
    acc = 0;
    for (longint j = 0; j < cnt; j++) begin
      num = 65536;
      den = 1;
      for (longint k = 0; k < cnt; k++) begin
        if (k != j) begin
          num = rnd16(num * (u - k * 65536));
          den = den * (j - k);
        end
      end
      age = m - (beg + j);
      s = age < WIN_LEN ? window[WIN_LEN - 1 - age] : 0;
      acc += s * div_nearest(num, den);
    end
    acc = rnd16(acc);
    if (acc < -32768) acc = -32768;
    if (acc > 32767) acc = 32767;
    return acc[15:0];
  endfunction

  task automatic resample_step(input logic signed [15:0] s, input logic lst);
    longint m, total, i, pos;
    bit fin;
    int cnt;
    out_word_t w;
    m = seg_inputs;
    if (m == 0) begin
      ratio_seg = ratio_reg;
      if (ratio_seg < RATIO_MIN) ratio_seg = RATIO_MIN;
      if (ratio_seg > RATIO_MAX) ratio_seg = RATIO_MAX;
    end
    for (int k = 0; k < WIN_LEN - 1; k++) window[k] = window[k + 1];
    window[WIN_LEN - 1] = s;
    fin = lst || (m + 1 >= MAX_SEGMENT_DEF);
    total = fin ? ((m + 1) * ratio_seg + 65535) >> 16 : 0;
    cnt = 0;
    while (cnt < MAX_RESULTS) begin
      i = seg_outputs;
      pos = (i << 32) / ratio_seg;
      if (fin ? (i >= total) : ((pos >>> 16) + HALF_WINDOW > m)) break;
      w.smp = interp_at(pos, m);
      w.lst = fin && (i + 1 == total);
      expected_words.push_back(w);
      seg_outputs = i + 1;
      cnt++;
    end
    if (fin) begin
      for (int k = 0; k < WIN_LEN; k++) window[k] = 0;
      seg_inputs = 0;
      seg_outputs = 0;
    end else begin
      seg_inputs = m + 1;
    end
  endtask

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    out_word_t w;
    in_took  = in_valid && in_ready;
    cfg_took = cfg_valid && cfg_ready;
    if (!rst) begin
      cycles++;
      if (cycles > MAX_CYCLE) begin
        $display("[lagrange_resampler_core] ERROR");
        $finish;
      end
      if (cfg_took) ratio_reg = ratio_q16;
      if (in_took) resample_step(sample_in, last_in);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: sample_out %0d last_out %0d", sample_out, last_out);
          fails++;
        end else begin
          w = expected_words.pop_front();
          if (sample_out !== w.smp) begin
            $error("sample_out: expected %0d, actual %0d", w.smp, sample_out);
            fails++;
          end
          if (last_out !== w.lst) begin
            $error("last_out: expected %0d, actual %0d", w.lst, last_out);
            fails++;
          end
        end
      end
      quiet = (in_took || (out_valid && out_ready)) ? 0 : quiet + 1;
    end
  end

  function automatic int pick_gap();
    if (nogap_left > 0) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 200);
  endfunction

  // driver
  always @(negedge clk) begin
    logic nv_in, nv_cfg;
    job_t j;
    nv_in  = in_valid && !in_took;
    nv_cfg = cfg_valid && !cfg_took;
    if (!rst && !nv_in && !nv_cfg) begin
      if (nogap_left > 0) nogap_left--;
      else if ($urandom_range(0, 99) == 0) nogap_left = $urandom_range(20, 60);
      if (gap > 0) begin
        gap--;
      end else if (jobs.size() == 0) begin
        stim_done = 1;
      end else begin
        j = jobs[0];
        case (j.kind)
          K_SAMPLE: begin
            nv_in = 1'b1;
            sample_in <= j.smp;
            last_in <= j.lst;
            void'(jobs.pop_front());
            gap = pick_gap();
          end
          K_RATIO: begin
            if (expected_words.size() == 0 && quiet >= QUIET) begin
              nv_cfg = 1'b1;
              ratio_q16 <= j.ratio;
              void'(jobs.pop_front());
            end
          end
          default: begin
            if (expected_words.size() == 0 && quiet >= QUIET) void'(jobs.pop_front());
          end
        endcase
      end
    end
    in_valid  <= nv_in;
    cfg_valid <= nv_cfg;
    if (ostall > 0) begin
      out_ready <= 1'b0;
      ostall--;
    end else begin
      out_ready <= 1'b1;
      if (nogap_left == 0 && $urandom_range(0, 3) == 0)
        ostall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 150);
    end
  end

  function automatic job_t mk_sample(input logic signed [15:0] s, input logic l);
    job_t j;
    j.kind = K_SAMPLE; j.smp = s; j.lst = l; j.ratio = '0;
    return j;
  endfunction

  function automatic job_t mk_ratio(input logic [RATIO_W-1:0] r);
    job_t j;
    j.kind = K_RATIO; j.smp = '0; j.lst = 1'b0; j.ratio = r;
    return j;
  endfunction

  initial begin
    job_t dj;
    int n, len, amp;
    seg_inputs = 0; seg_outputs = 0; ratio_reg = RATIO_RESET; ratio_seg = RATIO_RESET;
    for (int k = 0; k < WIN_LEN; k++) window[k] = 0;
    dj.kind = K_DRAIN; dj.smp = '0; dj.lst = 1'b0; dj.ratio = '0;

    // directed: reset ratio, single-sample segments, full-scale swings
    jobs.push_back(mk_sample(16'sh7FFF, 1'b1));
    jobs.push_back(mk_sample(-16'sd32768, 1'b1));
    for (int k = 0; k < 6; k++) jobs.push_back(mk_sample(k[0] ? 16'sh7FFF : -16'sd32768, k == 5));
    jobs.push_back(mk_ratio(RATIO_MAX));
    for (int k = 0; k < 4; k++) jobs.push_back(mk_sample(k[0] ? 16'sh7FFF : -16'sd32768, k == 3));
    jobs.push_back(mk_ratio(RATIO_MIN));
    for (int k = 0; k < 4; k++) jobs.push_back(mk_sample(16'(k * 1000 - 1), k == 3));
    // out of range ratios saturate when latched
    jobs.push_back(mk_ratio('0));
    jobs.push_back(mk_sample(16'sd1234, 1'b0));
    // write in the middle of a segment takes effect on the next one
    jobs.push_back(mk_ratio('1));
    jobs.push_back(mk_sample(-16'sd1, 1'b0));
    jobs.push_back(mk_sample(16'sd0, 1'b1));
    jobs.push_back(mk_sample(16'sh5555, 1'b1));
    jobs.push_back(dj);

    n = 0;
    while (n < 210) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: jobs.push_back(mk_ratio(RATIO_MIN));
          1: jobs.push_back(mk_ratio(RATIO_MAX));
          2: jobs.push_back(mk_ratio(RATIO_W'($urandom_range(0, 19'h7FFFF))));
          default: jobs.push_back(mk_ratio(RATIO_W'($urandom_range(RATIO_MIN, RATIO_MAX))));
        endcase
      end
      if ($urandom_range(0, 15) == 0) jobs.push_back(dj);
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
      amp = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        case (amp)
          0: jobs.push_back(mk_sample(16'($urandom), k == len - 1));
          1: jobs.push_back(mk_sample($signed(16'($urandom_range(0, 2047))) - 16'sd1024,
                                      k == len - 1));
          default: jobs.push_back(mk_sample($urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768,
                                            k == len - 1));
        endcase
      end
      n += len;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_words.size() == 0);
    repeat (QUIET) @(posedge clk);
    if (fails == 0 && expected_words.size() == 0) begin
      $display("[lagrange_resampler_core] OK");
    end else begin
      $display("[lagrange_resampler_core] ERROR");
    end
    $finish;
  end
endmodule

/* lagrange_resampler_core.f */
+incdir+rtl
rtl/lrs_pkg.sv
rtl/lrs_mul.sv
rtl/lrs_rdiv.sv
rtl/lagrange_resampler_core.sv
tb/sv/tb.sv
